[rtl/salc_pkg.sv]
// Shared constants, configuration register indexes, controller states and command struct.
package salc_pkg;

    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int STAMP_WIDTH_DEF  = 32;

    localparam int ADDR_W     = 64;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

    typedef enum logic
    {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed
    {
        logic capture;
        logic update;
    } ctl_t;

endpackage

[rtl/salc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module salc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/salc_ctrl.sv]
// Controller state machine that sequences the read and the write-back of one set.
module salc_ctrl
    import salc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    output logic done,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                state_next = start ? ST_LOOKUP : ST_IDLE;
            end
            ST_LOOKUP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                ctl.capture = start;
                ctl.update  = 1'b0;
            end
            ST_LOOKUP:
            begin
                busy        = 1'b1;
                ctl.capture = 1'b0;
                ctl.update  = 1'b1;
            end
            default:
            begin
                busy        = 1'b1;
                ctl.capture = 1'b0;
                ctl.update  = 1'b0;
            end
        endcase
        done_next = ctl.update;
    end

    assign done = done_reg;

endmodule

[rtl/salc_datapath.sv]
// Datapath: configuration registers, set RAM, tag compare, replacement choice and counters.
module salc_datapath
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int STAMP_WIDTH  = STAMP_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  opcode,
    output logic                  was_hit,
    output logic                  was_eviction,
    output logic [1:0]            hits_added,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total,
    output logic [CNT_W-1:0]      eviction_total
);

    localparam int IDX_W  = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int ROWS   = 1 << MAX_SET_BITS;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int LINE_W = 1 + ADDR_W + STAMP_WIDTH;
    localparam int ROW_W  = MAX_WAYS * LINE_W;

    logic [2:0]             set_bits_reg;
    logic [3:0]             ways_in_use_reg;
    logic [5:0]             block_bits_reg;

    logic [ROWS-1:0]        row_valid_reg;
    logic [IDX_W-1:0]       set_reg;
    logic [ADDR_W-1:0]      tag_reg;
    logic                   modify_reg;
    logic                   row_ok_reg;
    logic [STAMP_WIDTH-1:0] access_clock_reg;
    logic [STAMP_WIDTH-1:0] access_clock_next;
    logic [CNT_W-1:0]       hit_total_reg;
    logic [CNT_W-1:0]       hit_total_next;
    logic [CNT_W-1:0]       miss_total_reg;
    logic [CNT_W-1:0]       miss_total_next;
    logic [CNT_W-1:0]       eviction_total_reg;
    logic [CNT_W-1:0]       eviction_total_next;
    logic                   was_hit_reg;
    logic                   was_eviction_reg;
    logic [1:0]             hits_added_reg;
    logic [1:0]             hits_added_next;

    logic [2:0]             sb_eff;
    logic [6:0]             shift_sum;
    logic [ADDR_W-1:0]      set_shift;
    logic [IDX_W-1:0]       set_idx;
    logic [ADDR_W-1:0]      tag_in;

    logic [ROW_W-1:0]       rd_row;
    logic [ROW_W-1:0]       row_data;
    logic [ROW_W-1:0]       row_wr;
    logic                   hit;
    logic                   evict;
    logic [CNT_W:0]         hit_sum;

    always_comb
    begin
        sb_eff    = (int'(set_bits_reg) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_reg;
        shift_sum = {4'b0, sb_eff} + {1'b0, block_bits_reg};
        set_shift = address >> block_bits_reg;
        set_idx   = set_shift[IDX_W-1:0] & ~({IDX_W{1'b1}} << sb_eff);
        tag_in    = shift_sum[6] ? '0 : (address >> shift_sum[5:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg    <= 3'd0;
            ways_in_use_reg <= 4'd1;
            block_bits_reg  <= 6'd0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_SET_BITS:    set_bits_reg    <= cfg_wr_data[2:0];
                CFG_WAYS_IN_USE: ways_in_use_reg <= cfg_wr_data[3:0];
                CFG_BLOCK_BITS:  block_bits_reg  <= cfg_wr_data[5:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            set_reg    <= set_idx;
            tag_reg    <= tag_in;
            modify_reg <= opcode;
        end
        if (ctl.update)
        begin
            was_hit_reg      <= hit;
            was_eviction_reg <= evict;
            hits_added_reg   <= hits_added_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg      <= '0;
            row_ok_reg         <= 1'b0;
            access_clock_reg   <= '0;
            hit_total_reg      <= '0;
            miss_total_reg     <= '0;
            eviction_total_reg <= '0;
        end
        else
        begin
            if (ctl.capture)
            begin
                row_ok_reg <= row_valid_reg[set_idx];
            end
            if (ctl.update)
            begin
                row_valid_reg[set_reg] <= 1'b1;
                access_clock_reg       <= access_clock_next;
                hit_total_reg          <= hit_total_next;
                miss_total_reg         <= miss_total_next;
                eviction_total_reg     <= eviction_total_next;
            end
        end
    end

    salc_ram
    #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    )
    u_set_ram
    (
        .clk     (clk),
        .wr_en   (ctl.update),
        .wr_addr (set_reg),
        .wr_data (row_wr),
        .rd_en   (ctl.capture),
        .rd_addr (set_idx),
        .rd_data (rd_row)
    );

    always_comb
    begin
        logic                   line_valid [MAX_WAYS];
        logic [ADDR_W-1:0]      line_tag   [MAX_WAYS];
        logic [STAMP_WIDTH-1:0] line_stamp [MAX_WAYS];
        logic [MAX_WAYS-1:0]    in_use;
        logic [WAY_W-1:0]       hit_way;
        logic [WAY_W-1:0]       free_way;
        logic [WAY_W-1:0]       victim;
        logic [WAY_W-1:0]       target;
        logic [STAMP_WIDTH-1:0] min_stamp;
        logic                   has_free;

        row_data          = row_ok_reg ? rd_row : '0;
        access_clock_next = access_clock_reg + 1'b1;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            line_valid[w] = row_data[w*LINE_W + LINE_W - 1];
            line_tag[w]   = row_data[w*LINE_W + STAMP_WIDTH +: ADDR_W];
            line_stamp[w] = row_data[w*LINE_W +: STAMP_WIDTH];
            in_use[w]     = (w == 0) || (w < int'(ways_in_use_reg));
        end

        hit     = 1'b0;
        hit_way = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--)
        begin
            if (in_use[w] && line_valid[w] && (line_tag[w] == tag_reg))
            begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
        end

        has_free = 1'b0;
        free_way = '0;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && !line_valid[w])
            begin
                has_free = 1'b1;
                free_way = WAY_W'(w);
            end
        end

        victim    = '0;
        min_stamp = line_stamp[0];
        for (int w = 1; w < MAX_WAYS; w++)
        begin
            if (in_use[w] && (min_stamp > line_stamp[w]))
            begin
                min_stamp = line_stamp[w];
                victim    = WAY_W'(w);
            end
        end

        evict = !hit && !has_free;
        priority if (hit)
        begin
            target = hit_way;
        end
        else if (has_free)
        begin
            target = free_way;
        end
        else
        begin
            target = victim;
        end

        row_wr = row_data;
        for (int w = 0; w < MAX_WAYS; w++)
        begin
            if (target == WAY_W'(w))
            begin
                row_wr[w*LINE_W +: LINE_W] = {1'b1, tag_reg, access_clock_next};
            end
        end

        hits_added_next = {1'b0, hit} + {1'b0, modify_reg};
        hit_sum         = {1'b0, hit_total_reg} + {{(CNT_W - 1){1'b0}}, hits_added_next};
        hit_total_next  = hit_sum[CNT_W] ? '1 : hit_sum[CNT_W-1:0];
        miss_total_next = (!hit && (miss_total_reg != '1)) ?
                          miss_total_reg + 1'b1 : miss_total_reg;
        eviction_total_next = (evict && (eviction_total_reg != '1)) ?
                              eviction_total_reg + 1'b1 : eviction_total_reg;
    end

    assign was_hit        = was_hit_reg;
    assign was_eviction   = was_eviction_reg;
    assign hits_added     = hits_added_reg;
    assign hit_total      = hit_total_reg;
    assign miss_total     = miss_total_reg;
    assign eviction_total = eviction_total_reg;

`ifndef ASSERT_OFF
    a_row_marked: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> row_valid_reg[$past(set_reg)])
        else $error("set row not marked valid after write-back");

    a_clock_step: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> access_clock_reg == $past(access_clock_next))
        else $error("access clock did not advance by one");

    a_hit_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> hit_total_reg >= $past(hit_total_reg))
        else $error("hit total decreased");

    a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.update && !hit && (miss_total_reg != '1)) |=>
        miss_total_reg == $past(miss_total_reg) + 1'b1)
        else $error("miss total not incremented on a miss");

    a_evict_is_miss: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.update |=> !(was_hit_reg && was_eviction_reg))
        else $error("item flagged both hit and eviction");
`endif

endmodule

[rtl/set_assoc_lru_cache_sim.sv]
// Top level of the set-associative LRU cache model: controller plus datapath.
// An item is taken at a rising edge with start high and busy low. The set row is read from the
// set RAM at that edge, and in the following cycle (busy high) all ways in use are compared, the
// replacement way is chosen and the row is written back. No new item is taken while busy is
// high, a limit set by the single read then write-back of the set RAM. The result appears for
// exactly one cycle, marked by done, in the cycle after busy; the receiver cannot stall it and
// must take it then. Each set row has a valid bit that reset clears at once, so the block is
// ready right after reset with no clearing pass.
module set_assoc_lru_cache_sim
    import salc_pkg::*;
#(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int STAMP_WIDTH  = STAMP_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [ADDR_W-1:0]     address,
    input  logic                  opcode,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output logic                  done,
    output logic                  was_hit,
    output logic                  was_eviction,
    output logic [1:0]            hits_added,
    output logic [CNT_W-1:0]      hit_total,
    output logic [CNT_W-1:0]      miss_total,
    output logic [CNT_W-1:0]      eviction_total
);

    ctl_t ctl;

    salc_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    salc_datapath
    #(
        .MAX_SET_BITS (MAX_SET_BITS),
        .MAX_WAYS     (MAX_WAYS),
        .STAMP_WIDTH  (STAMP_WIDTH)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .address        (address),
        .opcode         (opcode),
        .was_hit        (was_hit),
        .was_eviction   (was_eviction),
        .hits_added     (hits_added),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the set-associative LRU cache simulator block.
module testbench;
    import salc_pkg::*;

    localparam int LINES = (1 << MAX_SET_BITS_DEF) * MAX_WAYS_DEF;
    localparam int POOL = 12;

    typedef struct packed
    {
        logic             hit;
        logic             evict;
        logic [1:0]       added;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evicts;
    } access_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [ADDR_W-1:0]     address;
    logic                  opcode;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  done;
    logic                  was_hit;
    logic                  was_eviction;
    logic [1:0]            hits_added;
    logic [CNT_W-1:0]      hit_total;
    logic [CNT_W-1:0]      miss_total;
    logic [CNT_W-1:0]      eviction_total;

    logic                       line_valid [LINES];
    logic [ADDR_W-1:0]          line_tag   [LINES];
    logic [STAMP_WIDTH_DEF-1:0] line_stamp [LINES];
    logic [STAMP_WIDTH_DEF-1:0] access_clock;
    logic [CNT_W-1:0]           model_hit_total;
    logic [CNT_W-1:0]           model_miss_total;
    logic [CNT_W-1:0]           evict_count;
    logic [2:0]                 geo_set_bits;
    logic [3:0]                 geo_ways;
    logic [5:0]                 geo_block_bits;

    access_result_t    pending_results[$];
    logic [ADDR_W-1:0] tag_pool[POOL];
    int                error_count = 0;
    bit                steady_flow = 1'b0;

    set_assoc_lru_cache_sim DUT
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .address        (address),
        .opcode         (opcode),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .done           (done),
        .was_hit        (was_hit),
        .was_eviction   (was_eviction),
        .hits_added     (hits_added),
        .hit_total      (hit_total),
        .miss_total     (miss_total),
        .eviction_total (eviction_total)
    );

    always #1 clk = ~clk;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic int active_set_bits();
        return (geo_set_bits > MAX_SET_BITS_DEF) ? MAX_SET_BITS_DEF : int'(geo_set_bits);
    endfunction

    function automatic access_result_t predict_access(input logic [ADDR_W-1:0] addr,
                                                      input logic op);
        int unsigned sb;
        int unsigned nways;
        int unsigned base;
        int unsigned victim;
        int unsigned free_way;
        int unsigned idx;
        int unsigned w;
        logic [ADDR_W-1:0] set_idx;
        logic [ADDR_W-1:0] tag;
        logic hit;
        logic has_free;
        logic evicted;
        access_result_t r;
        sb = active_set_bits();
        nways = (geo_ways == 0) ? 1 : ((geo_ways > MAX_WAYS_DEF) ? MAX_WAYS_DEF : geo_ways);
        set_idx = (addr >> geo_block_bits) & ((64'd1 << sb) - 64'd1);
        tag = (sb + geo_block_bits < ADDR_W) ? (addr >> (sb + geo_block_bits)) : '0;
        access_clock = access_clock + 1'b1;
        base = int'(set_idx) * MAX_WAYS_DEF;
        hit = 1'b0;
        has_free = 1'b0;
        evicted = 1'b0;
        victim = 0;
        free_way = 0;
        for (w = 0; w < nways && !hit; w++)
        begin
            idx = base + w;
            if (line_valid[idx])
            begin
                if (line_tag[idx] == tag)
                begin
                    line_stamp[idx] = access_clock;
                    hit = 1'b1;
                end
                else if (line_stamp[base + victim] > line_stamp[idx])
                begin
                    victim = w;
                end
            end
            else
            begin
                has_free = 1'b1;
                free_way = w;
            end
        end
        if (hit)
        begin
            model_hit_total = sat_inc(model_hit_total);
        end
        else
        begin
            model_miss_total = sat_inc(model_miss_total);
            if (has_free)
            begin
                idx = base + free_way;
                line_valid[idx] = 1'b1;
            end
            else
            begin
                idx = base + victim;
                evicted = 1'b1;
                evict_count = sat_inc(evict_count);
            end
            line_tag[idx] = tag;
            line_stamp[idx] = access_clock;
        end
        if (op)
        begin
            model_hit_total = sat_inc(model_hit_total);
        end
        r.hit = hit;
        r.evict = evicted;
        r.added = {1'b0, hit} + {1'b0, op};
        r.hits = model_hit_total;
        r.misses = model_miss_total;
        r.evicts = evict_count;
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 20);
    endfunction

    task automatic send_access(input logic [ADDR_W-1:0] addr, input logic op);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        address <= addr;
        opcode <= op;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        pending_results.push_back(predict_access(addr, op));
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    task automatic write_geometry(input logic [5:0] sb_data, input logic [5:0] ways_data,
                                  input logic [5:0] bb_data);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SET_BITS;
        cfg_wr_data <= sb_data;
        @(posedge clk);
        cfg_index <= CFG_WAYS_IN_USE;
        cfg_wr_data <= ways_data;
        @(posedge clk);
        cfg_index <= CFG_BLOCK_BITS;
        cfg_wr_data <= bb_data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        geo_set_bits = sb_data[2:0];
        geo_ways = ways_data[3:0];
        geo_block_bits = bb_data;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin
        access_result_t exp_r;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                check_field("was_hit", exp_r.hit, was_hit);
                check_field("was_eviction", exp_r.evict, was_eviction);
                check_field("hits_added", exp_r.added, hits_added);
                check_field("hit_total", exp_r.hits, hit_total);
                check_field("miss_total", exp_r.misses, miss_total);
                check_field("eviction_total", exp_r.evicts, eviction_total);
            end
        end
    end

    task automatic test_reset_geometry();
        send_access(64'h0, 1'b0);
        send_access(64'h0, 1'b1);
        send_access('1, 1'b0);
        send_access('1, 1'b1);
        send_access(64'h0, 1'b1);
    endtask

    task automatic test_geometry_extremes();
        write_geometry(6'h3F, 6'h0F, 6'h3F);
        send_access('1, 1'b0);
        send_access(64'h8000_0000_0000_0000, 1'b1);
        send_access(64'h0, 1'b0);
        write_geometry(6'd6, 6'h10, 6'd32);
        send_access(64'h0000_0040_0000_0000, 1'b0);
        send_access(64'hFFFF_FFC0_0000_0000, 1'b1);
        send_access(64'h0000_0040_0000_0000, 1'b0);
    endtask

    task automatic test_lru_order();
        int i;
        write_geometry(6'd0, 6'd8, 6'd0);
        for (i = 1; i <= 8; i++)
        begin
            send_access(64'(i), 1'b0);
        end
        send_access(64'd1, 1'b0);
        send_access(64'd9, 1'b0);
        send_access(64'd2, 1'b1);
    endtask

    function automatic logic [ADDR_W-1:0] random_address();
        int unsigned sb;
        int unsigned pick;
        logic [ADDR_W-1:0] set_val;
        logic [ADDR_W-1:0] offset;
        if ($urandom_range(0, 9) == 0)
        begin
            return {$urandom, $urandom};
        end
        sb = active_set_bits();
        pick = $urandom_range(0, ((geo_ways & 4'h7) + 4 > POOL - 1) ? POOL - 1
                                                                    : (geo_ways & 4'h7) + 4);
        if ($urandom_range(0, 1) == 1)
        begin
            pick = POOL - 1 - pick;
        end
        set_val = ($urandom_range(0, 4) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
        set_val = set_val & ((64'd1 << sb) - 64'd1);
        offset = {$urandom, $urandom} & ((64'd1 << geo_block_bits) - 64'd1);
        return (tag_pool[pick] << (sb + geo_block_bits)) | (set_val << geo_block_bits) | offset;
    endfunction

    task automatic test_random_traffic();
        int phase;
        int n;
        int i;
        logic [5:0] bb;
        for (phase = 0; phase < 12; phase++)
        begin
            for (i = 0; i < POOL; i++)
            begin
                tag_pool[i] = (i < POOL / 2) ? 64'(i) : {$urandom, $urandom};
            end
            bb = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                             : 6'($urandom_range(0, 6));
            case (phase)
                0: write_geometry(6'd6, 6'd8, 6'd0);
                1: write_geometry(6'd0, 6'd1, 6'd63);
                2: write_geometry(6'd7, 6'd15, 6'd32);
                3: write_geometry(6'd2, 6'd0, 6'd4);
                default: write_geometry(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), bb);
            endcase
            steady_flow = (phase % 4 == 3);
            for (n = 0; n < 100; n++)
            begin
                send_access(random_address(), 1'($urandom_range(0, 1)));
            end
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        int i;
        for (i = 0; i < LINES; i++)
        begin
            line_valid[i] = 1'b0;
            line_tag[i] = '0;
            line_stamp[i] = '0;
        end
        access_clock = '0;
        model_hit_total = '0;
        model_miss_total = '0;
        evict_count = '0;
        geo_set_bits = 3'd0;
        geo_ways = 4'd1;
        geo_block_bits = 6'd0;
        rst_n <= 1'b0;
        start <= 1'b0;
        address <= '0;
        opcode <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= CFG_SET_BITS;
        cfg_wr_data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_geometry();
        test_geometry_extremes();
        test_lru_order();
        test_random_traffic();
        wait_drained();
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial
    begin
        #1000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/salc_pkg.sv
rtl/salc_ram.sv
rtl/salc_ctrl.sv
rtl/salc_datapath.sv
rtl/set_assoc_lru_cache_sim.sv
verif/testbench.sv
